// ===== hdl/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg
// Shared widths, register indexes, payload types and the stencil sum.
// ----------------------------------------------------------------------------
package lds_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int POS_W        = 10;
    localparam int COEFF_W      = 16;
    localparam int LAP_W        = SAMPLE_W + 3;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_LINE_DEF = 1024;
    localparam int QUEUE_DEPTH  = 8;

    localparam logic [COEFF_W-1:0] COEFF_MAX = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_COEFF     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC       = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       line_end;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] new_value;
        logic [POS_W-1:0]           position;
        logic                       line_done;
    } out_t;

    // one pending result: center value, stencil sum, tags
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mid;
        logic signed [LAP_W-1:0]    lap;
        logic [POS_W-1:0]           pos;
        logic                       done;
    } job_t;

    // left + right - 2*mid, exact
    function automatic logic signed [LAP_W-1:0] lap_sum(
        input logic signed [SAMPLE_W-1:0] left,
        input logic signed [SAMPLE_W-1:0] mid,
        input logic signed [SAMPLE_W-1:0] right
    );
        logic signed [LAP_W-1:0] l_ext;
        logic signed [LAP_W-1:0] m_ext;
        logic signed [LAP_W-1:0] r_ext;
        l_ext = LAP_W'(left);
        m_ext = LAP_W'(mid);
        r_ext = LAP_W'(right);
        return l_ext + r_ext - (m_ext <<< 1);
    endfunction

endpackage

// ===== hdl/lds_stencil.sv =====
// ----------------------------------------------------------------------------
// lds_stencil
// Scales the stencil sum by D, rounds half up at bit 16, adds the center.
// ----------------------------------------------------------------------------
module lds_stencil (
    input  lds_pkg::job_t                  job,
    input  logic [lds_pkg::COEFF_W-1:0]    coeff,
    output lds_pkg::out_t                  result
);

    localparam int PROD_W = lds_pkg::LAP_W + lds_pkg::COEFF_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] scaled;

    assign prod    = $signed({1'b0, coeff}) * job.lap;
    assign rounded = prod + PROD_W'(32768);
    // arithmetic shift = floor, matching round-half-up on both signs
    assign scaled  = rounded >>> 16;

    assign result.new_value = job.mid + scaled[lds_pkg::SAMPLE_W-1:0];
    assign result.position  = job.pos;
    assign result.line_done = job.done;

endmodule

// ===== hdl/line_diffusion_stencil_top.sv =====
// ----------------------------------------------------------------------------
// line_diffusion_stencil_top
// One explicit diffusion step along a grid line, three-point stencil.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one cell per word (sample, line_end); m_* returns diffused
//   cells (new_value, position, line_done). cfg_* writes D, the boundary
//   value and the periodic flag; write only while the block is drained.
//   A cell's result leaves once its right neighbor has arrived. On the last
//   cell of a line the block emits the previous cell, the last cell and
//   then cell 0 (line_done set), so a line of N cells yields N words.
//   A result is written into the result queue when the word that releases
//   it is accepted, and reaches m_* through the output register.
//   Throughput: one cell per cycle while s_ready is high; each line end
//   pushes up to three results, drained by the single stencil multiplier.
//   s_ready drops while the 8-entry queue has less than 3 free slots.
//   A stalled m_ready holds the output word and backs up the queue.
//   Reset (aresetn low, synchronous) empties the queue, clears the output
//   valid, restarts the line at cell 0 and zeroes the config registers.
//   A cell at index MAX_LINE-1 closes its line even without line_end.
// ----------------------------------------------------------------------------
module line_diffusion_stencil_top #(
    parameter int MAX_LINE = lds_pkg::MAX_LINE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  lds_pkg::in_t                    s_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output lds_pkg::out_t                   m_data,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lds_pkg::SAMPLE_W-1:0]    cfg_data
);

    localparam int CNT_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int DEPTH = lds_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int QCNT_W = PTR_W + 1;

    // ---------------- configuration ----------------
    logic [lds_pkg::COEFF_W-1:0]         coeff_reg;
    logic signed [lds_pkg::SAMPLE_W-1:0] bound_reg;
    logic                                periodic_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg    <= '0;
            bound_reg    <= '0;
            periodic_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lds_pkg::CFG_DIFF_COEFF: begin
                    // D above one half acts as one half
                    coeff_reg <= (cfg_data[lds_pkg::COEFF_W-1:0] > lds_pkg::COEFF_MAX) ?
                                 lds_pkg::COEFF_MAX : cfg_data[lds_pkg::COEFF_W-1:0];
                end
                lds_pkg::CFG_BOUNDARY_VALUE: begin
                    bound_reg <= cfg_data;
                end
                lds_pkg::CFG_PERIODIC: begin
                    periodic_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- line state ----------------
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic signed [lds_pkg::SAMPLE_W-1:0] first_reg;
    logic signed [lds_pkg::SAMPLE_W-1:0] second_reg;
    logic signed [lds_pkg::SAMPLE_W-1:0] older_reg;
    logic signed [lds_pkg::SAMPLE_W-1:0] newer_reg;

    // ---------------- result queue ----------------
    lds_pkg::job_t       q_mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   q_count_reg, q_count_next;

    logic                accept;
    logic                pop;
    logic                out_load;
    logic [1:0]          n_push;
    lds_pkg::job_t       slot [3];

    logic [31:0]                         idx;
    logic                                last;
    logic signed [lds_pkg::SAMPLE_W-1:0] s;
    logic signed [lds_pkg::SAMPLE_W-1:0] second_eff;
    logic signed [lds_pkg::SAMPLE_W-1:0] edge_left;
    logic signed [lds_pkg::SAMPLE_W-1:0] edge_right;
    lds_pkg::job_t                       job_mid;
    lds_pkg::job_t                       job_tail;
    lds_pkg::job_t                       job_head;
    lds_pkg::job_t                       job_single;

    assign s_ready = (q_count_reg <= QCNT_W'(DEPTH - 3));
    assign accept  = s_valid && s_ready;

    assign idx  = 32'(cnt_reg);
    assign s    = s_data.sample;
    assign last = s_data.line_end || (idx >= 32'(MAX_LINE - 1));

    always_comb begin
        // cell 1 becomes visible in the same word that closes a two-cell line
        second_eff = (idx == 32'd1) ? s : second_reg;
        edge_left  = periodic_reg ? s         : bound_reg;
        edge_right = periodic_reg ? first_reg : bound_reg;

        job_mid.mid  = newer_reg;
        job_mid.lap  = lds_pkg::lap_sum(older_reg, newer_reg, s);
        job_mid.pos  = lds_pkg::POS_W'(idx - 32'd1);
        job_mid.done = 1'b0;

        job_tail.mid  = s;
        job_tail.lap  = lds_pkg::lap_sum(newer_reg, s, edge_right);
        job_tail.pos  = idx[lds_pkg::POS_W-1:0];
        job_tail.done = 1'b0;

        job_head.mid  = first_reg;
        job_head.lap  = lds_pkg::lap_sum(edge_left, first_reg, second_eff);
        job_head.pos  = '0;
        job_head.done = 1'b1;

        // one-cell line: both neighbors are the edge, or the cell itself
        job_single.mid  = s;
        job_single.lap  = lds_pkg::lap_sum(edge_left, s, edge_left);
        job_single.pos  = '0;
        job_single.done = 1'b1;

        priority if (idx >= 32'd2) begin
            slot[0] = job_mid;
            slot[1] = job_tail;
            slot[2] = job_head;
            n_push  = last ? 2'd3 : 2'd1;
        end else if (idx == 32'd1) begin
            slot[0] = job_tail;
            slot[1] = job_head;
            slot[2] = job_head;
            n_push  = last ? 2'd2 : 2'd0;
        end else begin
            slot[0] = job_single;
            slot[1] = job_single;
            slot[2] = job_single;
            n_push  = last ? 2'd1 : 2'd0;
        end
        if (!accept) begin
            n_push = 2'd0;
        end
    end

    assign cnt_next = last ? '0 : cnt_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (idx == 32'd0) begin
                first_reg <= s;
            end
            if (idx == 32'd1) begin
                second_reg <= s;
            end
            older_reg <= newer_reg;
            newer_reg <= s;
        end
    end

    // queue write: up to three entries per accepted word
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < n_push) begin
                q_mem[wr_ptr_reg + PTR_W'(k)] <= slot[k];
            end
        end
    end

    // ---------------- stencil and output register ----------------
    lds_pkg::out_t  stencil_out;
    lds_pkg::out_t  m_data_reg;
    logic           m_valid_reg, m_valid_next;

    lds_stencil u_stencil (
        .job    (q_mem[rd_ptr_reg]),
        .coeff  (coeff_reg),
        .result (stencil_out)
    );

    assign out_load     = !m_valid_reg || m_ready;
    assign pop          = out_load && (q_count_reg != '0);
    assign m_valid_next = out_load ? (q_count_reg != '0) : m_valid_reg;

    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign q_count_next = q_count_reg + QCNT_W'(n_push) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= stencil_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= QCNT_W'(DEPTH))
        else $error("result queue overflow");

    a_done_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.line_done |-> m_data.position == '0)
        else $error("line_done on a cell other than 0");

    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.line_end |=> cnt_reg == '0)
        else $error("line end did not restart the cell count");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_count_reg != '0))
        else $error("output raised with an empty queue");
`endif

endmodule

// ===== tb/tb_line_diffusion_stencil_top.sv =====
// ----------------------------------------------------------------------------
// tb_line_diffusion_stencil_top
// Self-checking bench for the three-point diffusion stencil along grid lines.
// Cells stream in through a bursty driver and results are taken by a stalling
// receiver. A behavioral model of the stencil predicts every result word, and
// a scoreboard compares the words field by field, in order. The run starts
// with short directed lines and then moves to random lines under many
// coefficient, boundary and wrap settings.
// ----------------------------------------------------------------------------
module tb_line_diffusion_stencil_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int LINE_LIMIT    = lds_pkg::MAX_LINE_DEF;
    localparam int RANDOM_CELLS  = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs start at known values)
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    lds_pkg::in_t                        s_data    = '0;

    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    lds_pkg::out_t                       m_data;

    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [lds_pkg::CFG_IDX_W-1:0]       cfg_index = lds_pkg::CFG_DIFF_COEFF;
    logic [lds_pkg::SAMPLE_W-1:0]        cfg_data  = '0;

    always #(HALF_PERIOD) aclk = ~aclk;

    line_diffusion_stencil_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Stencil model: its own copy of the registers and the line state
    // ------------------------------------------------------------------
    logic [lds_pkg::COEFF_W-1:0]         model_coeff    = '0;
    logic signed [lds_pkg::SAMPLE_W-1:0] model_boundary = '0;
    logic                                model_wrap     = 1'b0;

    logic signed [lds_pkg::SAMPLE_W-1:0] cell_zero  = '0;  // cell 0 of the open line
    logic signed [lds_pkg::SAMPLE_W-1:0] cell_one   = '0;  // cell 1 of the open line
    logic signed [lds_pkg::SAMPLE_W-1:0] cell_back2 = '0;  // two words back
    logic signed [lds_pkg::SAMPLE_W-1:0] cell_back1 = '0;  // previous word
    int unsigned                         line_index = 0;   // index of the next cell

    lds_pkg::in_t  pending_cells [$];     // stimulus waiting for the driver
    lds_pkg::out_t expected_results [$];  // predicted words, oldest first

    int error_count  = 0;
    int random_cells = 0;

    // f + D*(left + right - 2f); product rounded to nearest, ties upward.
    // D is clamped at one half. Arithmetic shift of the 64-bit sum is the floor.
    function automatic logic signed [lds_pkg::SAMPLE_W-1:0] diffuse(
        input logic signed [lds_pkg::SAMPLE_W-1:0] left,
        input logic signed [lds_pkg::SAMPLE_W-1:0] mid,
        input logic signed [lds_pkg::SAMPLE_W-1:0] right
    );
        longint coeff;
        longint lap;
        longint prod;
        coeff = (model_coeff > lds_pkg::COEFF_MAX) ? longint'(lds_pkg::COEFF_MAX)
                                                   : longint'(model_coeff);
        lap   = longint'(left) + longint'(right) - 2 * longint'(mid);
        prod  = coeff * lap + 64'sd32768;
        return lds_pkg::SAMPLE_W'(longint'(mid) + (prod >>> 16));
    endfunction

    function automatic void add_result(
        input logic signed [lds_pkg::SAMPLE_W-1:0] value,
        input int unsigned                         pos,
        input logic                                done
    );
        lds_pkg::out_t w;
        w.new_value = value;
        w.position  = lds_pkg::POS_W'(pos);
        w.line_done = done;
        expected_results.push_back(w);
    endfunction

    // One accepted cell: emit the middle cell it completes, and on a line
    // end the last cell and then cell 0.
    function automatic void predict_cell(input lds_pkg::in_t c);
        logic signed [lds_pkg::SAMPLE_W-1:0] s;
        logic signed [lds_pkg::SAMPLE_W-1:0] edge_l;
        logic signed [lds_pkg::SAMPLE_W-1:0] edge_r;
        logic                                last;
        int unsigned                         i;
        s    = c.sample;
        last = c.line_end;
        i    = line_index;
        if (i >= LINE_LIMIT - 1)
            last = 1'b1;   // over-long line closes itself
        if (i == 0) begin
            cell_zero  = s;
            cell_back1 = s;
        end
        if (i == 1)
            cell_one = s;
        if (i >= 2)
            add_result(diffuse(cell_back2, cell_back1, s), i - 1, 1'b0);
        if (last) begin
            if (i == 0) begin
                // single cell line: both neighbors are the edge (or itself)
                edge_l = model_wrap ? s : model_boundary;
                add_result(diffuse(edge_l, s, edge_l), 0, 1'b1);
            end else begin
                edge_r = model_wrap ? cell_zero : model_boundary;
                edge_l = model_wrap ? s : model_boundary;
                add_result(diffuse(cell_back1, s, edge_r), i, 1'b0);
                add_result(diffuse(edge_l, cell_zero, cell_one), 0, 1'b1);
            end
            line_index = 0;
        end else begin
            line_index = i + 1;
        end
        cell_back2 = cell_back1;
        cell_back1 = s;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: config, input and output handshakes sampled at the edge.
    // Inputs are predicted before outputs are checked, so ordering inside
    // the step never matters.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        lds_pkg::out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lds_pkg::CFG_DIFF_COEFF:
                        model_coeff    = cfg_data[lds_pkg::COEFF_W-1:0];
                    lds_pkg::CFG_BOUNDARY_VALUE:
                        model_boundary = cfg_data;
                    lds_pkg::CFG_PERIODIC:
                        model_wrap     = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_cell(s_data);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_error($sformatf("word with nothing pending: value %h pos %0d done %0b",
                                         m_data.new_value, m_data.position, m_data.line_done));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.new_value !== want.new_value)
                        note_error($sformatf("new_value exp %h got %h (pos %0d)",
                                             want.new_value, m_data.new_value, want.position));
                    if (m_data.position !== want.position)
                        note_error($sformatf("position exp %0d got %0d",
                                             want.position, m_data.position));
                    if (m_data.line_done !== want.line_done)
                        note_error($sformatf("line_done exp %0b got %0b (pos %0d)",
                                             want.line_done, m_data.line_done, want.position));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of words separated by random gaps; valid holds with
    // the payload frozen until the word is taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // word still waiting, keep it
        end else if (gap_left != 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (pending_cells.size() != 0) begin
            s_data  <= pending_cells.pop_front();
            s_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches between random modes, from always ready
    // down to mostly stalled.
    // ------------------------------------------------------------------
    int stall_mode   = 0;
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (stall_cycles == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stall_cycles = $urandom_range(16, 96);
        end
        stall_cycles--;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_cell(input logic signed [lds_pkg::SAMPLE_W-1:0] v,
                                      input logic fin);
        lds_pkg::in_t c;
        c.sample   = v;
        c.line_end = fin;
        pending_cells.push_back(c);
    endfunction

    function automatic logic signed [lds_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1:       return lds_pkg::SAMPLE_W'($urandom_range(0, 131071)) - 32'sd65536;
            default: return $urandom();
        endcase
    endfunction

    // random cell values; line_end only on the closing cell
    task automatic queue_line(input int len);
        for (int k = 0; k < len; k++)
            push_cell(pick_sample(), k == len - 1);
    endtask

    task automatic write_reg(input logic [lds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lds_pkg::SAMPLE_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(
        input logic [lds_pkg::COEFF_W-1:0]  coeff,
        input logic [lds_pkg::SAMPLE_W-1:0] bval,
        input logic                         wrap
    );
        write_reg(lds_pkg::CFG_DIFF_COEFF, lds_pkg::SAMPLE_W'(coeff));
        write_reg(lds_pkg::CFG_BOUNDARY_VALUE, bval);
        write_reg(lds_pkg::CFG_PERIODIC, lds_pkg::SAMPLE_W'(wrap));
    endtask

    // sender holds off until every predicted word is back, then through a settle
    // period so the block is truly idle; checked mid-cycle once all edge
    // updates have settled
    task automatic drain();
        while (pending_cells.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [lds_pkg::COEFF_W-1:0]  coeff;
        logic [lds_pkg::SAMPLE_W-1:0] bval;
        int                           phase_cells;
        int                           len;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset registers: D = 0 so every cell passes through unchanged
        push_cell(32'sd1, 1'b0);
        push_cell(32'sd2, 1'b0);
        push_cell(32'sd3, 1'b1);
        drain();

        // D at one half, fixed edge at the positive extreme
        set_config(lds_pkg::COEFF_MAX, 32'h7fff_ffff, 1'b0);
        push_cell(32'sh8000_0000, 1'b1);               // one cell line
        push_cell(32'sh7fff_ffff, 1'b0);               // two cell line
        push_cell(32'sh8000_0000, 1'b1);
        push_cell(32'sh8000_0000, 1'b0);
        push_cell(32'sh7fff_ffff, 1'b0);
        push_cell(32'sh8000_0000, 1'b1);
        push_cell(-32'sd1, 1'b0);
        push_cell(32'sd0, 1'b0);
        push_cell(32'sd1, 1'b0);
        push_cell(32'sh7fff_ffff, 1'b0);
        push_cell(-32'sd1, 1'b1);
        drain();

        // coefficient above one half (acts as one half), wrapped line ends
        set_config(16'hffff, 32'h8000_0000, 1'b1);
        push_cell(32'sh7fff_ffff, 1'b1);               // wraps onto itself
        push_cell(32'sd1, 1'b0);
        push_cell(-32'sd1, 1'b1);
        push_cell(32'sh8000_0000, 1'b0);
        push_cell(32'sh7fff_ffff, 1'b0);
        push_cell(32'sh1234_5678, 1'b0);
        push_cell(-32'sd65536, 1'b1);
        drain();

        // random phases, each with fresh register settings
        while (random_cells < RANDOM_CELLS) begin
            case ($urandom_range(0, 6))
                0:       coeff = 16'd0;
                1:       coeff = 16'd1;
                2:       coeff = 16'd32767;
                3:       coeff = lds_pkg::COEFF_MAX;
                4:       coeff = 16'($urandom_range(32769, 65535));
                default: coeff = 16'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 4))
                0:       bval = 32'h8000_0000;
                1:       bval = 32'h7fff_ffff;
                2:       bval = 32'h0;
                default: bval = $urandom();
            endcase
            set_config(coeff, bval, 1'($urandom_range(0, 1)));

            phase_cells = 0;
            while (phase_cells < 50) begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = 2;
                    2:       len = 3;
                    3:       len = $urandom_range(40, 80);
                    default: len = $urandom_range(4, 16);
                endcase
                queue_line(len);
                phase_cells += len;
            end
            random_cells += phase_cells;
            drain();
        end

        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_line_diffusion_stencil_top: PASS");
        else
            $display("tb_line_diffusion_stencil_top: FAIL");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_line_diffusion_stencil_top: FAIL");
        $finish;
    end

endmodule
